// ----- hdl/spwm_pkg.sv -----
`timescale 1ns / 1ps
package spwm_pkg;

    typedef enum logic [1:0] {
        CMD_RAW   = 2'd0,
        CMD_POS   = 2'd1,
        CMD_ANGLE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_CENTER = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    localparam int CNT_W   = 12;
    localparam int US_W    = 15;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;

    localparam logic [CNT_W-1:0] RST_CNT_LEFT   = 12'd205;
    localparam logic [CNT_W-1:0] RST_CNT_CENTER = 12'd307;
    localparam logic [CNT_W-1:0] RST_CNT_RIGHT  = 12'd410;

    localparam logic [7:0] POS_CENTER = 8'd128;
    localparam logic [7:0] POS_RIGHT  = 8'd255;
    localparam logic [7:0] ANG_CENTER = 8'd90;
    localparam logic [7:0] ANG_RIGHT  = 8'd180;

    // ceil(2^32 / d) for d = 625, 255, 90
    localparam logic [22:0] RECIP_625 = 23'd6871948;
    localparam logic [25:0] RECIP_255 = 26'd16843010;
    localparam logic [25:0] RECIP_90  = 26'd47721859;
    localparam int          RECIP_SH  = 32;

    // half-step bias plus den * BIAS_K keeps the dividend positive
    localparam int               BIAS_K   = 8192;
    localparam logic [21:0]      OFS_255  = 22'(127 + 255 * BIAS_K);
    localparam logic [21:0]      OFS_90   = 22'(45 + 90 * BIAS_K);
    localparam logic signed [16:0] BIAS_Q = 17'(BIAS_K);

endpackage

// ----- hdl/servo_pulse_width_mapper_top.sv -----
`timescale 1ns / 1ps
// Servo pulse width mapper.
// Slave stream s_axis_*: one command per transaction, tuser = cmd, tdata = channel and value.
// Master stream m_axis_*: one result per command, tdata = channel and 12-bit PWM on-count.
// Command code 3 is accepted and dropped without a result.
// Config channel i_cfg_*: index 0/1/2 writes the left/center/right pulse width in us;
// the width is converted to a count in the cycle of the write. Write only while idle.
// A result passes through the input register, product register, quotient register and
// result register, in that order, after its command is accepted.
// Throughput: one command per cycle while s_axis_tready is high; the product and the
// reciprocal multiply each have a register stage of their own.
// Reset: pipeline emptied, widths return to 1000/1500/2000 us.
// Stall: when m_axis_tready is low the pipeline fills; s_axis_tready falls only once
// every stage holds a transaction, and no result is lost or repeated.
module servo_pulse_width_mapper_top
    import spwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] channel, [19:4] value, [23:20] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] out_channel, [15:4] pulse_count

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    function automatic logic [CNT_W-1:0] us_to_count(input logic [US_W-1:0] us);
        logic [22:0] half;
        logic [45:0] prod;
        logic [13:0] quot;
        half = {1'b0, us, 7'd0} + 23'd312;
        prod = half * RECIP_625;
        quot = prod[45:RECIP_SH];
        if (quot > {2'b00, CNT_MAX}) begin
            return CNT_MAX;
        end
        return quot[CNT_W-1:0];
    endfunction

    logic [CNT_W-1:0] r_cnt_l, r_cnt_c, r_cnt_r;

    logic               r_v1;
    t_cmd               r_cmd;
    logic [CHAN_W-1:0]  r_chan1;
    logic [VALUE_W-1:0] r_value;

    logic               r_v2;
    logic signed [21:0] r_prod;
    logic signed [13:0] r_base2;
    logic               r_den90_2;
    logic               r_direct2;
    logic [CNT_W-1:0]   r_dval2;
    logic [CHAN_W-1:0]  r_chan2;

    logic               r_v3;
    logic [15:0]        r_quot;
    logic signed [13:0] r_base3;
    logic               r_direct3;
    logic [CNT_W-1:0]   r_dval3;
    logic [CHAN_W-1:0]  r_chan3;

    logic               r_vo;
    logic [CHAN_W-1:0]  r_ochan;
    logic [CNT_W-1:0]   r_pcount;

    logic rdy_o, rdy3, rdy2, rdy1;
    t_cmd in_cmd;

    assign rdy_o = !r_vo || m_axis_tready;
    assign rdy3  = !r_v3 || rdy_o;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign o_cfg_ready   = 1'b1;
    assign in_cmd        = t_cmd'(s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_l <= RST_CNT_LEFT;
            r_cnt_c <= RST_CNT_CENTER;
            r_cnt_r <= RST_CNT_RIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LEFT:   r_cnt_l <= us_to_count(i_cfg_data);
                REG_CENTER: r_cnt_c <= us_to_count(i_cfg_data);
                REG_RIGHT:  r_cnt_r <= us_to_count(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage 1: select the mapping and form the product
    logic                n_direct;
    logic [CNT_W-1:0]    n_dval;
    logic signed [12:0]  n_diff;
    logic signed [13:0]  n_base;
    logic [7:0]          n_k;
    logic                n_den90;
    logic signed [21:0]  n_prod;
    logic signed [12:0]  s_l, s_c, s_r;
    logic [7:0]          lo8;

    assign s_l = $signed({1'b0, r_cnt_l});
    assign s_c = $signed({1'b0, r_cnt_c});
    assign s_r = $signed({1'b0, r_cnt_r});
    assign lo8 = r_value[7:0];

    always_comb begin
        n_direct = 1'b1;
        n_dval   = r_cnt_l;
        n_diff   = '0;
        n_base   = '0;
        n_k      = lo8;
        n_den90  = 1'b0;
        case (r_cmd)
            CMD_RAW: begin
                if (r_value > {4'd0, r_cnt_r}) begin
                    n_dval = r_cnt_r;
                end else if (r_value < {4'd0, r_cnt_l}) begin
                    n_dval = r_cnt_l;
                end else begin
                    n_dval = r_value[CNT_W-1:0];
                end
            end
            CMD_POS: begin
                if (lo8 == POS_CENTER) begin
                    n_dval = r_cnt_c;
                end else if (lo8 == POS_RIGHT) begin
                    n_dval = r_cnt_r;
                end else begin
                    n_direct = 1'b0;
                    n_diff   = s_r - s_l;
                    n_base   = 14'(s_l);
                end
            end
            CMD_ANGLE: begin
                n_den90 = 1'b1;
                if (lo8 == ANG_CENTER) begin
                    n_dval = r_cnt_c;
                end else if (lo8 >= ANG_RIGHT) begin
                    n_dval = r_cnt_r;
                end else if (lo8 < ANG_CENTER) begin
                    n_direct = 1'b0;
                    n_diff   = s_c - s_l;
                    n_base   = 14'(s_l);
                end else begin
                    n_direct = 1'b0;
                    n_diff   = s_r - s_c;
                    n_base   = 14'(s_c) + 14'(s_c) - 14'(s_r);
                end
            end
            default: ;
        endcase
    end

    assign n_prod = n_diff * $signed({1'b0, n_k});

    // stage 2: bias and divide by reciprocal
    logic [22:0] n_sum;
    logic [47:0] n_qprod;

    assign n_sum   = {r_prod[21], r_prod} + {1'b0, (r_den90_2 ? OFS_90 : OFS_255)};
    assign n_qprod = n_sum[21:0] * (r_den90_2 ? RECIP_90 : RECIP_255);

    // stage 3: rebase and saturate
    logic signed [16:0] n_res;
    logic [CNT_W-1:0]   n_pcount;

    always_comb begin
        n_res = $signed({1'b0, r_quot}) - BIAS_Q + 17'(r_base3);
        if (r_direct3) begin
            n_pcount = r_dval3;
        end else if (n_res < 0) begin
            n_pcount = '0;
        end else if (n_res > $signed({5'd0, CNT_MAX})) begin
            n_pcount = CNT_MAX;
        end else begin
            n_pcount = n_res[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid && (in_cmd != CMD_NONE);
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy_o) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_cmd   <= in_cmd;
            r_chan1 <= s_axis_tdata[3:0];
            r_value <= s_axis_tdata[19:4];
        end
        if (rdy2) begin
            r_prod    <= n_prod;
            r_base2   <= n_base;
            r_den90_2 <= n_den90;
            r_direct2 <= n_direct;
            r_dval2   <= n_dval;
            r_chan2   <= r_chan1;
        end
        if (rdy3) begin
            r_quot    <= n_qprod[47:RECIP_SH];
            r_base3   <= r_base2;
            r_direct3 <= r_direct2;
            r_dval3   <= r_dval2;
            r_chan3   <= r_chan2;
        end
        if (rdy_o) begin
            r_ochan  <= r_chan3;
            r_pcount <= n_pcount;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_pcount, r_ochan};

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_vo && !m_axis_tready))
        else $error("input stalled while pipeline has room");

    a_no_unused_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_cmd != CMD_NONE))
        else $error("unused command entered pipeline");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_v3))
        else $error("result appeared without a quotient stage transaction");

endmodule
